// ===== hdl/rrsp_pkg.sv =====
// Package for the reply stream parser: phase and command types, event and
// element codes, character constants. No dependencies.
package rrsp_pkg;

    localparam int MAX_RESULTS = 10;

    localparam logic [2:0] EV_DATA  = 3'd0;
    localparam logic [2:0] EV_DONE  = 3'd1;
    localparam logic [2:0] EV_OPEN  = 3'd2;
    localparam logic [2:0] EV_CLOSE = 3'd3;
    localparam logic [2:0] EV_ERROR = 3'd4;

    localparam logic [2:0] TY_SIMPLE = 3'd0;
    localparam logic [2:0] TY_ERROR  = 3'd1;
    localparam logic [2:0] TY_ASK    = 3'd2;
    localparam logic [2:0] TY_MOVED  = 3'd3;
    localparam logic [2:0] TY_INT    = 3'd4;
    localparam logic [2:0] TY_BULK   = 3'd5;
    localparam logic [2:0] TY_NULL   = 3'd6;
    localparam logic [2:0] TY_ARRAY  = 3'd7;

    localparam logic [2:0] PFX_START = 3'd0;
    localparam logic [2:0] PFX_A     = 3'd1;
    localparam logic [2:0] PFX_AS    = 3'd2;
    localparam logic [2:0] PFX_M     = 3'd3;
    localparam logic [2:0] PFX_MO    = 3'd4;
    localparam logic [2:0] PFX_MOV   = 3'd5;
    localparam logic [2:0] PFX_MOVE  = 3'd6;
    localparam logic [2:0] PFX_DONE  = 3'd7;

    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_COLON = 8'h3A;
    localparam logic [7:0] C_DOLL  = 8'h24;
    localparam logic [7:0] C_STAR  = 8'h2A;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_0     = 8'h30;
    localparam logic [7:0] C_9     = 8'h39;
    localparam logic [7:0] C_UA    = 8'h41;
    localparam logic [7:0] C_US    = 8'h53;
    localparam logic [7:0] C_UK    = 8'h4B;
    localparam logic [7:0] C_UM    = 8'h4D;
    localparam logic [7:0] C_UO    = 8'h4F;
    localparam logic [7:0] C_UV    = 8'h56;
    localparam logic [7:0] C_UE    = 8'h45;
    localparam logic [7:0] C_UD    = 8'h44;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_LINE    = 6'b000010,
        PH_INT     = 6'b000100,
        PH_BULK    = 6'b001000,
        PH_BULK_CR = 6'b010000,
        PH_BULK_LF = 6'b100000
    } t_phase;

    typedef enum logic [2:0] {
        CK_DATA,
        CK_FINISH,
        CK_OPEN,
        CK_FAIL,
        CK_ABORT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [2:0]  ety;
        logic [7:0]  byt;
        logic [63:0] val;
        logic        cr;
        logic        has_byte;
    } t_cmd;

endpackage

// ===== hdl/rrsp_if.sv =====
// Channel interfaces of the reply stream parser: input bytes and events.
// Depends on nothing.
interface rrsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       abort;
    modport source (output valid, in_byte, abort, input ready);
    modport sink (input valid, in_byte, abort, output ready);
endinterface

interface rrsp_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         event_res;
    logic [2:0]         elem_type;
    logic [7:0]         data_byte;
    logic signed [63:0] int_value;
    logic [3:0]         nest_depth;
    logic               reply_end;
    logic               last;
    modport source (output valid, event_res, elem_type, data_byte, int_value,
                    nest_depth, reply_end, last, input ready);
    modport sink (input valid, event_res, elem_type, data_byte, int_value,
                  nest_depth, reply_end, last, output ready);
endinterface

// ===== hdl/resp_reply_stream_parser.sv =====
// Reply stream parser top level: front end, command queue, back end.
// Depends on rrsp_pkg, rrsp_if, rrsp_front, rrsp_queue, rrsp_back.
//
// Usage: reply bytes enter on i_in, one byte per beat; abort set on a beat
// drops any partial reply and gives no event. Events leave on o_out, each
// beat one event (data byte, element done, array opened or closed, protocol
// error); last marks the final event caused by one input byte.
// An event passes through the command queue and the output register after
// its byte is accepted. Throughput: one byte per cycle while the queue is not
// full; the back end gives the events of a byte one at a time (a CR resolved
// as text, then its byte; an element done, then each array that it closes).
// A four-beat command queue between front and back end lets bytes keep
// arriving while the back end walks closing arrays.
// Reset: synchronous, active low; parser idle, no open arrays, no events.
// When the receiver stalls the output register holds its event, the back
// end stops, and once the queue fills i_in.ready drops.
module resp_reply_stream_parser
    import rrsp_pkg::*;
#(
    parameter int MAX_DEPTH  = 8,
    parameter int COUNT_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rrsp_in_if.sink    i_in,
    rrsp_out_if.source o_out
);

    t_cmd                           cmd;
    logic                           cmd_valid;
    t_cmd                           head;
    logic                           q_empty;
    logic                           q_full;
    logic                           pop;
    logic [$clog2(MAX_DEPTH+1)-1:0] depth;

    rrsp_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_full      (q_full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    rrsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    rrsp_back #(.MAX_DEPTH(MAX_DEPTH), .COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_depth (depth),
        .o_out   (o_out)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_valid |-> !q_full)
        else $error("command pushed into full queue");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        depth <= ($clog2(MAX_DEPTH+1))'(MAX_DEPTH))
        else $error("array stack deeper than limit");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.event_res == EV_ERROR) |->
            (o_out.nest_depth == 4'd0 && o_out.int_value == 64'sd0 && o_out.last))
        else $error("malformed protocol error event");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule

// ===== hdl/rrsp_front.sv =====
// Front end: classifies each byte, parses numbers and text, and issues
// commands to the back end. Depends on rrsp_pkg and rrsp_in_if.
module rrsp_front
    import rrsp_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrsp_in_if.sink     i_in,
    input  logic        i_full,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd
);

    t_phase                r_phase, n_phase;
    logic [2:0]            r_ty, n_ty;
    logic [63:0]           r_acc, n_acc;
    logic                  r_neg, n_neg;
    logic                  r_dig, n_dig;
    logic                  r_pcr, n_pcr;
    logic [2:0]            r_pfx, n_pfx;
    logic [COUNT_BITS-1:0] r_brem, n_brem;

    logic        fire;
    logic [7:0]  c;
    logic        is_digit;
    logic [67:0] acc_next;
    logic [67:0] limit;
    logic [63:0] sval;
    logic        fail_now;
    logic        clr;

    assign i_in.ready = !i_full;
    assign fire       = i_in.valid && !i_full;
    assign c          = i_in.in_byte;
    assign is_digit   = (c >= C_0) && (c <= C_9);
    assign acc_next   = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                      + {64'd0, 4'(c - C_0)};
    assign limit      = r_neg ? 68'h0_8000_0000_0000_0000 : 68'h0_7FFF_FFFF_FFFF_FFFF;
    assign sval       = r_neg ? (64'd0 - r_acc) : r_acc;

    always_comb begin
        n_phase     = r_phase;
        n_ty        = r_ty;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_dig       = r_dig;
        n_pcr       = r_pcr;
        n_pfx       = r_pfx;
        n_brem      = r_brem;
        o_cmd_valid = 1'b0;
        o_cmd       = '{kind: CK_DATA, ety: r_ty, byt: c, val: 64'd0,
                        cr: 1'b0, has_byte: 1'b0};
        fail_now    = 1'b0;
        clr         = 1'b0;
        if (fire) begin
            if (i_in.abort) begin
                o_cmd_valid = 1'b1;
                o_cmd.kind  = CK_ABORT;
                clr         = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        priority if (c == C_PLUS) begin
                            n_phase = PH_LINE;
                            n_ty    = TY_SIMPLE;
                        end else if (c == C_MINUS) begin
                            n_phase = PH_LINE;
                            n_ty    = TY_ERROR;
                            n_pfx   = PFX_START;
                        end else if (c == C_COLON) begin
                            n_phase = PH_INT;
                            n_ty    = TY_INT;
                        end else if (c == C_DOLL) begin
                            n_phase = PH_INT;
                            n_ty    = TY_BULK;
                        end else if (c == C_STAR) begin
                            n_phase = PH_INT;
                            n_ty    = TY_ARRAY;
                        end else begin
                            fail_now = 1'b1;
                        end
                    end
                    PH_LINE: begin
                        if (r_pcr && c == C_LF) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.kind  = CK_FINISH;
                            clr         = 1'b1;
                        end else if (r_pcr) begin
                            // lone CR is text; CR itself ends any prefix match
                            o_cmd_valid    = 1'b1;
                            o_cmd.cr       = 1'b1;
                            o_cmd.has_byte = (c != C_CR);
                            if (r_ty == TY_ERROR) n_pfx = PFX_DONE;
                            n_pcr = (c == C_CR);
                        end else if (c == C_CR) begin
                            n_pcr = 1'b1;
                        end else begin
                            o_cmd_valid    = 1'b1;
                            o_cmd.has_byte = 1'b1;
                            if (r_ty == TY_ERROR && r_pfx != PFX_DONE) begin
                                n_pfx = PFX_DONE;
                                unique case (r_pfx)
                                    PFX_START: begin
                                        if (c == C_UA) n_pfx = PFX_A;
                                        if (c == C_UM) n_pfx = PFX_M;
                                    end
                                    PFX_A:    if (c == C_US) n_pfx = PFX_AS;
                                    PFX_AS:   if (c == C_UK) n_ty = TY_ASK;
                                    PFX_M:    if (c == C_UO) n_pfx = PFX_MO;
                                    PFX_MO:   if (c == C_UV) n_pfx = PFX_MOV;
                                    PFX_MOV:  if (c == C_UE) n_pfx = PFX_MOVE;
                                    PFX_MOVE: if (c == C_UD) n_ty = TY_MOVED;
                                    default:  n_pfx = PFX_DONE;
                                endcase
                            end
                        end
                    end
                    PH_INT: begin
                        if (r_pcr) begin
                            if (c != C_LF || !r_dig) begin
                                fail_now = 1'b1;
                            end else if (r_ty == TY_INT) begin
                                o_cmd_valid = 1'b1;
                                o_cmd.kind  = CK_FINISH;
                                o_cmd.val   = sval;
                                clr         = 1'b1;
                            end else if (r_neg) begin
                                if (r_acc == 64'd1) begin
                                    o_cmd_valid = 1'b1;
                                    o_cmd.kind  = CK_FINISH;
                                    o_cmd.ety   = TY_NULL;
                                    o_cmd.val   = sval;
                                    clr         = 1'b1;
                                end else begin
                                    fail_now = 1'b1;
                                end
                            end else if (r_acc[63:COUNT_BITS] != '0) begin
                                fail_now = 1'b1;
                            end else if (r_ty == TY_BULK) begin
                                n_brem  = r_acc[COUNT_BITS-1:0];
                                n_pcr   = 1'b0;
                                n_phase = (r_acc == 64'd0) ? PH_BULK_CR : PH_BULK;
                            end else if (r_acc == 64'd0) begin
                                o_cmd_valid = 1'b1;
                                o_cmd.kind  = CK_FINISH;
                                clr         = 1'b1;
                            end else begin
                                o_cmd_valid = 1'b1;
                                o_cmd.kind  = CK_OPEN;
                                o_cmd.val   = r_acc;
                                clr         = 1'b1;
                            end
                        end else if (c == C_CR) begin
                            n_pcr = 1'b1;
                        end else if (c == C_MINUS && !r_dig && !r_neg) begin
                            n_neg = 1'b1;
                        end else if (is_digit) begin
                            if (acc_next > limit) begin
                                fail_now = 1'b1;
                            end else begin
                                n_acc = acc_next[63:0];
                                n_dig = 1'b1;
                            end
                        end else begin
                            fail_now = 1'b1;
                        end
                    end
                    PH_BULK: begin
                        o_cmd_valid    = 1'b1;
                        o_cmd.ety      = TY_BULK;
                        o_cmd.has_byte = 1'b1;
                        n_brem         = r_brem - COUNT_BITS'(1);
                        if (r_brem == COUNT_BITS'(1)) n_phase = PH_BULK_CR;
                    end
                    PH_BULK_CR: begin
                        if (c == C_CR) n_phase = PH_BULK_LF;
                        else fail_now = 1'b1;
                    end
                    PH_BULK_LF: begin
                        if (c == C_LF) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.kind  = CK_FINISH;
                            o_cmd.ety   = TY_BULK;
                            o_cmd.val   = r_acc;
                            clr         = 1'b1;
                        end else begin
                            fail_now = 1'b1;
                        end
                    end
                    default: fail_now = 1'b1;
                endcase
            end
            if (fail_now) begin
                o_cmd_valid = 1'b1;
                o_cmd.kind  = CK_FAIL;
                clr         = 1'b1;
            end
            if (clr) begin
                n_phase = PH_IDLE;
                n_ty    = TY_SIMPLE;
                n_acc   = 64'd0;
                n_neg   = 1'b0;
                n_dig   = 1'b0;
                n_pcr   = 1'b0;
                n_pfx   = PFX_START;
                n_brem  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ty    <= TY_SIMPLE;
            r_acc   <= 64'd0;
            r_neg   <= 1'b0;
            r_dig   <= 1'b0;
            r_pcr   <= 1'b0;
            r_pfx   <= PFX_START;
            r_brem  <= '0;
        end else begin
            r_phase <= n_phase;
            r_ty    <= n_ty;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_dig   <= n_dig;
            r_pcr   <= n_pcr;
            r_pfx   <= n_pfx;
            r_brem  <= n_brem;
        end
    end

endmodule

// ===== hdl/rrsp_queue.sv =====
// Four-entry command queue between front and back end.
// Depends on rrsp_pkg.
module rrsp_queue
    import rrsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    t_cmd       r_mem [4];
    logic [1:0] r_wp, n_wp;
    logic [1:0] r_rp, n_rp;
    logic [2:0] r_cnt, n_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == 3'd0);
    assign o_full  = (r_cnt == 3'd4);

    always_comb begin
        n_wp  = r_wp + 2'(i_push);
        n_rp  = r_rp + 2'(i_pop);
        n_cnt = r_cnt + 3'(i_push) - 3'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== hdl/rrsp_back.sv =====
// Back end: keeps the array stack, turns commands into events, walks closing
// arrays one per cycle unless the output stalls; uses rrsp_pkg, rrsp_out_if.
module rrsp_back
    import rrsp_pkg::*;
#(
    parameter int MAX_DEPTH  = 8,
    parameter int COUNT_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_head,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic [$clog2(MAX_DEPTH+1)-1:0] o_depth,
    rrsp_out_if.source                    o_out
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    typedef enum logic [2:0] {
        BS_IDLE  = 3'b001,
        BS_BYTE  = 3'b010,
        BS_CLOSE = 3'b100
    } t_bstate;

    t_bstate               r_bs, n_bs;
    t_cmd                  r_cur, n_cur;
    logic [DW-1:0]         r_d, n_d;
    logic [COUNT_BITS-1:0] r_arr [MAX_DEPTH];
    logic [3:0]            r_cnt, n_cnt;
    logic                  r_ov;
    logic [2:0]            r_ev, r_ty;
    logic [7:0]            r_byte;
    logic [63:0]           r_val;
    logic [3:0]            r_nd;
    logic                  r_end, r_last;

    logic                  adv;
    t_cmd                  c;
    logic [3:0]            cnt_cur;
    logic [IW-1:0]         ti;
    logic [COUNT_BITS-1:0] top;
    logic                  has_par;
    logic                  follow;
    logic                  emit;
    logic                  emit_ok;
    logic [2:0]            e_ev, e_ty;
    logic [7:0]            e_byte;
    logic [63:0]           e_val;
    logic [DW-1:0]         e_d;
    logic                  e_end, e_last;
    logic                  wr_top, wr_new;

    assign adv     = !r_ov || o_out.ready;
    assign c       = (r_bs == BS_IDLE) ? i_head : r_cur;
    assign cnt_cur = (r_bs == BS_IDLE) ? 4'd0 : r_cnt;
    assign ti      = (r_bs == BS_CLOSE) ? IW'(r_d - DW'(2)) : IW'(r_d - DW'(1));
    assign top     = r_arr[ti];
    assign has_par = (r_bs == BS_CLOSE) ? (r_d > DW'(1)) : (r_d != '0);
    assign follow  = has_par && (top == COUNT_BITS'(1));
    assign emit_ok = emit && (cnt_cur < 4'(MAX_RESULTS));
    assign o_depth = r_d;

    always_comb begin
        n_bs   = r_bs;
        n_cur  = r_cur;
        n_d    = r_d;
        n_cnt  = r_cnt;
        o_pop  = 1'b0;
        emit   = 1'b0;
        e_ev   = EV_DATA;
        e_ty   = c.ety;
        e_byte = 8'd0;
        e_val  = 64'd0;
        e_d    = r_d;
        e_end  = 1'b0;
        e_last = 1'b1;
        wr_top = 1'b0;
        wr_new = 1'b0;
        if (adv) begin
            unique case (r_bs)
                BS_IDLE: begin
                    if (!i_empty) begin
                        o_pop = 1'b1;
                        n_cur = i_head;
                        unique case (i_head.kind)
                            CK_DATA: begin
                                emit = 1'b1;
                                if (i_head.cr) begin
                                    e_byte = C_CR;
                                    e_last = !i_head.has_byte;
                                    if (i_head.has_byte) n_bs = BS_BYTE;
                                end else begin
                                    e_byte = i_head.byt;
                                end
                            end
                            CK_FINISH: begin
                                emit   = 1'b1;
                                e_ev   = EV_DONE;
                                e_val  = i_head.val;
                                e_end  = (r_d == '0);
                                e_last = !follow;
                                wr_top = has_par;
                                if (follow) n_bs = BS_CLOSE;
                            end
                            CK_OPEN: begin
                                emit = 1'b1;
                                if (r_d >= DW'(MAX_DEPTH)) begin
                                    e_ev   = EV_ERROR;
                                    e_ty   = TY_SIMPLE;
                                    e_byte = i_head.byt;
                                    e_d    = '0;
                                    n_d    = '0;
                                end else begin
                                    e_ev   = EV_OPEN;
                                    e_ty   = TY_ARRAY;
                                    e_val  = i_head.val;
                                    wr_new = 1'b1;
                                    n_d    = r_d + DW'(1);
                                end
                            end
                            CK_FAIL: begin
                                emit   = 1'b1;
                                e_ev   = EV_ERROR;
                                e_ty   = TY_SIMPLE;
                                e_byte = i_head.byt;
                                e_d    = '0;
                                n_d    = '0;
                            end
                            default: n_d = '0;
                        endcase
                    end
                end
                BS_BYTE: begin
                    emit   = 1'b1;
                    e_byte = r_cur.byt;
                    n_bs   = BS_IDLE;
                end
                BS_CLOSE: begin
                    emit   = 1'b1;
                    e_ev   = EV_CLOSE;
                    e_ty   = TY_ARRAY;
                    e_d    = r_d - DW'(1);
                    e_end  = (r_d == DW'(1));
                    e_last = !follow;
                    wr_top = has_par;
                    n_d    = r_d - DW'(1);
                    if (!follow) n_bs = BS_IDLE;
                end
                default: n_bs = BS_IDLE;
            endcase
            n_cnt = emit_ok ? (cnt_cur + 4'd1) : cnt_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_top) r_arr[ti] <= top - COUNT_BITS'(1);
        if (wr_new) r_arr[r_d[IW-1:0]] <= i_head.val[COUNT_BITS-1:0];
        if (adv) begin
            r_ev   <= e_ev;
            r_ty   <= e_ty;
            r_byte <= e_byte;
            r_val  <= e_val;
            r_nd   <= 4'(e_d);
            r_end  <= e_end;
            r_last <= e_last || (cnt_cur == 4'(MAX_RESULTS - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs  <= BS_IDLE;
            r_cur <= '{kind: CK_ABORT, ety: 3'd0, byt: 8'd0, val: 64'd0,
                       cr: 1'b0, has_byte: 1'b0};
            r_d   <= '0;
            r_cnt <= 4'd0;
            r_ov  <= 1'b0;
        end else begin
            r_bs  <= n_bs;
            r_cur <= n_cur;
            r_d   <= n_d;
            r_cnt <= n_cnt;
            if (adv) r_ov <= emit_ok;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.event_res  = r_ev;
    assign o_out.elem_type  = r_ty;
    assign o_out.data_byte  = r_byte;
    assign o_out.int_value  = r_val;
    assign o_out.nest_depth = r_nd;
    assign o_out.reply_end  = r_end;
    assign o_out.last       = r_last;

endmodule

// ===== bench/tb_rrsp_checker.sv =====
// Checker for the reply stream parser: watches the byte and event channels,
// predicts the events of each accepted byte and compares them in order.
// Depends on rrsp_pkg and rrsp_if.
module tb_rrsp_checker
    import rrsp_pkg::*;
#(
    parameter int MAX_DEPTH  = 8,
    parameter int COUNT_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rrsp_in_if   i_in_mon,
    rrsp_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [2:0]  ev;
        logic [2:0]  ty;
        logic [7:0]  byt;
        logic [63:0] val;
        logic [3:0]  depth;
        logic        rend;
        logic        lst;
    } t_evt;

    t_evt        expected_events[$];
    t_evt        step_events[$];

    t_phase      phase;
    logic [2:0]  cur_type;
    logic [63:0] accum;
    logic        neg;
    logic        digit_seen;
    logic        pend_cr;
    logic [2:0]  pfx;
    logic [63:0] bulk_left;
    logic [63:0] arr_left[MAX_DEPTH];
    int          depth;

    function automatic void emit_evt(logic [2:0] ev, logic [2:0] ty, logic [7:0] b,
                                     logic [63:0] v, int d, logic e);
        t_evt x;
        if (step_events.size() >= MAX_RESULTS) return;
        x = '{ev, ty, b, v, d[3:0], e, 1'b0};
        step_events.insert(step_events.size(), x);
    endfunction

    function automatic void clear_elem();
        phase = PH_IDLE;
        cur_type = TY_SIMPLE;
        accum = '0;
        neg = 1'b0;
        digit_seen = 1'b0;
        pend_cr = 1'b0;
        pfx = PFX_START;
        bulk_left = '0;
    endfunction

    function automatic void clear_all();
        clear_elem();
        for (int i = 0; i < MAX_DEPTH; i++) arr_left[i] = '0;
        depth = 0;
    endfunction

    function automatic void proto_error(logic [7:0] b);
        emit_evt(EV_ERROR, TY_SIMPLE, b, '0, 0, 1'b0);
        clear_all();
    endfunction

    function automatic void elem_done(logic [2:0] ty, logic [63:0] v);
        emit_evt(EV_DONE, ty, 8'h00, v, depth, depth == 0);
        while (depth > 0) begin
            arr_left[depth-1] = arr_left[depth-1] - 1;
            if (arr_left[depth-1] != 0) break;
            depth--;
            emit_evt(EV_CLOSE, TY_ARRAY, 8'h00, '0, depth, depth == 0);
        end
        clear_elem();
    endfunction

    function automatic void text_char(logic [7:0] c);
        emit_evt(EV_DATA, cur_type, c, '0, depth, 1'b0);
        if (cur_type != TY_ERROR || pfx == PFX_DONE) return;
        case (pfx)
            PFX_START: pfx = (c == C_UA) ? PFX_A : (c == C_UM) ? PFX_M : PFX_DONE;
            PFX_A:     pfx = (c == C_US) ? PFX_AS : PFX_DONE;
            PFX_AS: begin
                if (c == C_UK) cur_type = TY_ASK;
                pfx = PFX_DONE;
            end
            PFX_M:     pfx = (c == C_UO) ? PFX_MO : PFX_DONE;
            PFX_MO:    pfx = (c == C_UV) ? PFX_MOV : PFX_DONE;
            PFX_MOV:   pfx = (c == C_UE) ? PFX_MOVE : PFX_DONE;
            PFX_MOVE: begin
                if (c == C_UD) cur_type = TY_MOVED;
                pfx = PFX_DONE;
            end
            default:   pfx = PFX_DONE;
        endcase
    endfunction

    function automatic void number_end(logic [7:0] c);
        logic [63:0] mag;
        logic [63:0] v;
        mag = accum;
        v = neg ? (64'd0 - mag) : mag;
        if (!digit_seen) begin
            proto_error(c);
        end else if (cur_type == TY_INT) begin
            elem_done(TY_INT, v);
        end else if (neg) begin
            if (mag == 64'd1) elem_done(TY_NULL, v);
            else proto_error(c);
        end else if ((mag >> COUNT_BITS) != 0) begin
            proto_error(c);
        end else if (cur_type == TY_BULK) begin
            bulk_left = mag;
            pend_cr = 1'b0;
            phase = (mag == 0) ? PH_BULK_CR : PH_BULK;
        end else if (mag == 0) begin
            elem_done(TY_ARRAY, '0);
        end else if (depth >= MAX_DEPTH) begin
            proto_error(c);
        end else begin
            emit_evt(EV_OPEN, TY_ARRAY, 8'h00, mag, depth, 1'b0);
            arr_left[depth] = mag;
            depth++;
            clear_elem();
        end
    endfunction

    function automatic void predict_beat(logic [7:0] c, logic abrt);
        logic [63:0] d;
        logic [63:0] lim;
        step_events.delete();
        if (abrt) begin
            clear_all();
            return;
        end
        case (phase)
            PH_IDLE: begin
                if (c == C_PLUS) begin
                    phase = PH_LINE; cur_type = TY_SIMPLE;
                end else if (c == C_MINUS) begin
                    phase = PH_LINE; cur_type = TY_ERROR; pfx = PFX_START;
                end else if (c == C_COLON) begin
                    phase = PH_INT; cur_type = TY_INT;
                end else if (c == C_DOLL) begin
                    phase = PH_INT; cur_type = TY_BULK;
                end else if (c == C_STAR) begin
                    phase = PH_INT; cur_type = TY_ARRAY;
                end else begin
                    proto_error(c);
                end
            end
            PH_LINE: begin
                if (pend_cr && c == C_LF) begin
                    elem_done(cur_type, '0);
                end else begin
                    if (pend_cr) begin
                        text_char(C_CR);
                        pend_cr = 1'b0;
                    end
                    if (c == C_CR) pend_cr = 1'b1;
                    else text_char(c);
                end
            end
            PH_INT: begin
                if (pend_cr) begin
                    if (c == C_LF) number_end(c);
                    else proto_error(c);
                end else if (c == C_CR) begin
                    pend_cr = 1'b1;
                end else if (c == C_MINUS && !digit_seen && !neg) begin
                    neg = 1'b1;
                end else if (c >= C_0 && c <= C_9) begin
                    d = 64'(c - C_0);
                    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                    if (accum > (lim - d) / 10) begin
                        proto_error(c);
                    end else begin
                        accum = accum * 10 + d;
                        digit_seen = 1'b1;
                    end
                end else begin
                    proto_error(c);
                end
            end
            PH_BULK: begin
                emit_evt(EV_DATA, TY_BULK, c, '0, depth, 1'b0);
                if (bulk_left > 0) bulk_left--;
                if (bulk_left == 0) phase = PH_BULK_CR;
            end
            PH_BULK_CR: begin
                if (c == C_CR) phase = PH_BULK_LF;
                else proto_error(c);
            end
            PH_BULK_LF: begin
                if (c == C_LF) elem_done(TY_BULK, accum);
                else proto_error(c);
            end
            default: proto_error(c);
        endcase
        if (step_events.size() > 0) step_events[step_events.size()-1].lst = 1'b1;
        foreach (step_events[i])
            expected_events.insert(expected_events.size(), step_events[i]);
    endfunction

    t_evt got;
    t_evt want;

    assign o_pending = expected_events.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_all();
            expected_events.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = '{i_out_mon.event_res, i_out_mon.elem_type, i_out_mon.data_byte,
                        i_out_mon.int_value, i_out_mon.nest_depth, i_out_mon.reply_end,
                        i_out_mon.last};
                if (expected_events.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected event: %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_events[0];
                    expected_events.delete(0);
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display({"event mismatch: expected ev=%0d ty=%0d b=%h v=%0d",
                                      " d=%0d e=%b l=%b, got ev=%0d ty=%0d b=%h v=%0d",
                                      " d=%0d e=%b l=%b"},
                                     want.ev, want.ty, want.byt, $signed(want.val),
                                     want.depth, want.rend, want.lst, got.ev, got.ty,
                                     got.byt, $signed(got.val), got.depth, got.rend,
                                     got.lst);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                predict_beat(i_in_mon.in_byte, i_in_mon.abort);
        end
    end

endmodule

// ===== bench/tb_resp_reply_stream_parser.sv =====
// Testbench top for the reply stream parser: clock, reset, reply byte stimulus
// with bursty sending and a stalling receiver, verdict.
// Depends on rrsp_pkg, rrsp_if, resp_reply_stream_parser, tb_rrsp_checker.
module tb_resp_reply_stream_parser;
    import rrsp_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int BYTE_GOAL  = 430;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    int   rx_mode;
    int   rx_count;

    logic [8:0] byte_stream[$];

    rrsp_in_if  in_ch();
    rrsp_out_if out_ch();

    resp_reply_stream_parser uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    tb_rrsp_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_mon    (in_ch),
        .i_out_mon   (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            byte_stream.insert(byte_stream.size(), {1'b0, s[i]});
    endfunction

    function automatic void put_byte(logic [7:0] b);
        byte_stream.insert(byte_stream.size(), {1'b0, b});
    endfunction

    function automatic void put_abort();
        byte_stream.insert(byte_stream.size(), {1'b1, 8'($urandom)});
    endfunction

    function automatic void put_text(bit with_cr);
        int n;
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
            if (with_cr && $urandom_range(0, 5) == 0) put_byte(C_CR);
            put_byte(8'($urandom_range(32, 126)));
        end
        put_str("\r\n");
    endfunction

    function automatic string rand_number();
        case ($urandom_range(0, 7))
            0: return "-9223372036854775808";
            1: return "9223372036854775807";
            2: return "9223372036854775808";
            3: return $sformatf("%0d", $urandom_range(0, 99));
            default: return $sformatf("%0d", longint'({$urandom, $urandom}));
        endcase
    endfunction

    function automatic void gen_reply(int lvl);
        int n;
        case ($urandom_range(0, 9))
            0, 1: begin
                put_byte(C_PLUS);
                put_text(1'b1);
            end
            2: begin
                put_byte(C_MINUS);
                case ($urandom_range(0, 4))
                    0: put_str("ASK ");
                    1: put_str("MOVED ");
                    2: put_str("AS");
                    3: put_str("MOV");
                    default: ;
                endcase
                put_text(1'b1);
            end
            3, 4: begin
                put_byte(C_COLON);
                put_str({rand_number(), "\r\n"});
            end
            5, 6: begin
                if ($urandom_range(0, 7) == 0) begin
                    put_str("$-1\r\n");
                end else begin
                    n = $urandom_range(0, 5);
                    put_str($sformatf("$%0d\r\n", n));
                    for (int i = 0; i < n; i++) put_byte(8'($urandom));
                    put_str("\r\n");
                end
            end
            7, 8: begin
                if (lvl >= 3) begin
                    put_str(":7\r\n");
                end else if ($urandom_range(0, 9) == 0) begin
                    put_str("*-1\r\n");
                end else begin
                    n = $urandom_range(0, 3);
                    put_str($sformatf("*%0d\r\n", n));
                    for (int i = 0; i < n; i++) gen_reply(lvl + 1);
                end
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: put_byte(8'($urandom));
                    1: begin
                        put_str("$3\r\nab");
                        put_abort();
                    end
                    2: put_str("$1\r\nxyz");
                    default: put_str(":12a\r\n");
                endcase
            end
        endcase
    endfunction

    // receiver stall pattern, mode picked at random at intervals set by rx_count
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_count <= 0;
            rx_mode <= 0;
        end else begin
            rx_count <= rx_count + 1;
            if (rx_count % 64 == 0) rx_mode <= $urandom_range(0, 3);
            case (rx_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 1) == 1);
                2: out_ch.ready <= (rx_count % 4 == 0);
                default: out_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int idx;
        int burst;
        int gap;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.in_byte <= 8'h00;
        in_ch.abort <= 1'b0;

        // directed replies and special cases
        put_str("+OK\r\n");
        put_str("+\r\n");
        put_str("+a\rb\r\n");
        put_str("-ASK 1\r\n");
        put_str("-MOVED 2\r\n");
        put_str("-ERR x\r\n");
        put_str(":-9223372036854775808\r\n");
        put_str(":9223372036854775807\r\n");
        put_str(":9223372036854775808\r\n");
        put_str(":-\r\n");
        put_str(":5\rx");
        put_str("$0\r\n\r\n");
        put_str("$-1\r\n");
        put_str("$-2\r\n");
        put_str("$4294967296\r\n");
        put_str("$2\r\n");
        put_byte(8'h00);
        put_byte(8'hFF);
        put_str("\r\n");
        put_str("$1\r\nab");
        put_str("*-1\r\n");
        put_str("*0\r\n");
        put_str("*2\r\n:1\r\n*1\r\n+x\r\n");
        for (int i = 0; i < 9; i++) put_str("*1\r\n");
        put_byte(8'h7E);
        put_str("*3\r\n:1");
        put_abort();
        put_str("+after\r\n");

        while (byte_stream.size() < BYTE_GOAL) gen_reply(0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idx = 0;
        while (idx < byte_stream.size()) begin
            burst = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            for (int k = 0; k < burst && idx < byte_stream.size(); k++) begin
                in_ch.valid <= 1'b1;
                in_ch.in_byte <= byte_stream[idx][7:0];
                in_ch.abort <= byte_stream[idx][8];
                @(posedge i_clk);
                while (!in_ch.ready) @(posedge i_clk);
                idx++;
            end
            if (gap > 0 || idx >= byte_stream.size()) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
